// ===== rtl/core/chm_pkg.sv =====
package chm_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_W        = 64;
  localparam int VAL_W        = 64;
  localparam int COUNT_W      = 11;

  // request codes carried on tuser
  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_DEL   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

endpackage

// ===== rtl/core/chm_ram.sv =====
module chm_ram #(
  parameter int DEPTH = chm_pkg::CAPACITY_DEF,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/chm_mod.sv =====
module chm_mod #(
  parameter int CAP = chm_pkg::CAPACITY_DEF,
  parameter int BW  = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [chm_pkg::KEY_W-1:0] key,
  output logic                     done,
  output logic [BW-1:0]            bucket
);

  import chm_pkg::*;

  localparam bit POW2  = ((CAP & (CAP - 1)) == 0);
  localparam int TW    = BW + 4;
  localparam int NDIG  = KEY_W / 4;
  localparam int CW    = $clog2(NDIG);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [KEY_W-1:0] sh;
  logic [BW-1:0]   acc;
  logic [TW-1:0]   t;
  logic [TW-1:0]   r;

  // one hex digit a step: reduce {acc, digit} below CAP with parallel compares
  always_comb begin
    t = {acc, sh[KEY_W-1 -: 4]};
    r = t;
    for (int q = 1; q < 16; q++) begin
      if (t >= TW'(q * CAP)) begin
        r = t - TW'(q * CAP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= start ? POW2 : (busy && (cnt == CW'(NDIG - 1)));
      if (start) begin
        if (POW2) begin
          bucket <= key[BW-1:0] & BW'(CAP - 1);
        end else begin
          sh   <= key;
          acc  <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        acc <= BW'(r);
        sh  <= sh << 4;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NDIG - 1)) begin
          busy   <= 1'b0;
          bucket <= BW'(r);
        end
      end
    end
  end

endmodule

// ===== rtl/core/chained_hash_map_engine_core.sv =====
// chained hash map engine: 64-bit key to 64-bit value map in a pool of
// CAPACITY nodes, chained per bucket (bucket = key mod CAPACITY)
// input channel s_*: one request word, tuser = request code
// (get, set, delete, clear), tdata = key and store value
// output channel m_*: exactly one result word per request, in order
// the block takes one request at a time; s_tready is high only when idle
// hash: a power-of-two capacity masks the low key bits, else the key goes
// one hex digit per step through the remainder unit, then the bucket is picked up
// get: hash, bucket head read, then a walk of the chain, one node
// per cycle through the key/link memory read port
// set: get walk, unlink when the key was held, then pop a node and walk to the
// chain tail, one node per cycle; a set dropped on a full pool ends after the get walk
// delete: get walk, then unlink when the key is found; clear: a sweep as at reset
// reset starts a sweep over every index that empties the buckets and
// refills the free stack; no request is taken meanwhile
// the result sits in an output register; a stalled receiver holds it
// and the next request may run until its own result is ready to load
module chained_hash_map_engine_core #(
  parameter int CAPACITY = chm_pkg::CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // lookup_key, store_value
  input  logic [1:0]   s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,   // read_value, live_count, zero pad
  output logic [1:0]   m_tuser    // hit, full_error
);

  import chm_pkg::*;

  localparam int BW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);

  typedef enum logic [12:0] {
    S_SWEEP   = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_HASH    = 13'b0000000000100,
    S_HEAD    = 13'b0000000001000,
    S_HEADW   = 13'b0000000010000,
    S_CMP     = 13'b0000000100000,
    S_UNLINK  = 13'b0000001000000,
    S_INS     = 13'b0000010000000,
    S_POPW    = 13'b0000100000000,
    S_THEAD   = 13'b0001000000000,
    S_THEADW  = 13'b0010000000000,
    S_TWALK   = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t state;

  req_t             req;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] val;
  logic [BW-1:0]    bkt;
  logic [IW-1:0]    cur;
  logic [IW-1:0]    prev;
  logic [IW-1:0]    nlink;
  logic [IW-1:0]    newnode;
  logic [IW-1:0]    steps;
  logic [IW-1:0]    used;
  logic [IW-1:0]    sw_idx;
  logic             sw_from_req;

  logic             res_hit;
  logic             res_err;
  logic [VAL_W-1:0] res_val;

  logic             out_hit;
  logic             out_err;
  logic [VAL_W-1:0] out_val;
  logic [COUNT_W-1:0] out_cnt;

  logic [IW-1:0]    used_dec;
  logic [IW-1:0]    steps_inc;

  // hash unit
  logic             hash_start;
  logic             hash_done;
  logic [BW-1:0]    hash_bkt;

  // memory ports
  logic             bh_we;
  logic [BW-1:0]    bh_waddr;
  logic [IW-1:0]    bh_wdata;
  logic [BW-1:0]    bh_raddr;
  logic [IW-1:0]    bh_rdata;

  logic             st_we;
  logic [BW-1:0]    st_waddr;
  logic [IW-1:0]    st_wdata;
  logic [BW-1:0]    st_raddr;
  logic [IW-1:0]    st_rdata;

  logic             nd_we;
  logic [BW-1:0]    nd_waddr;
  logic [BW-1:0]    nd_raddr;
  logic [KEY_W-1:0] key_rdata;
  logic [VAL_W-1:0] val_rdata;

  logic             ln_we;
  logic [BW-1:0]    ln_waddr;
  logic [IW-1:0]    ln_wdata;
  logic [IW-1:0]    ln_rdata;

  logic             accept;
  logic             out_free;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign hash_start = accept && (req_t'(s_tuser) != REQ_CLEAR);
  assign out_free   = !m_tvalid || m_tready;
  assign used_dec   = used - 1'b1;
  assign steps_inc  = steps + 1'b1;

  assign m_tdata = {5'd0, out_cnt, out_val};
  assign m_tuser = {out_err, out_hit};

  chm_mod #(.CAP(CAPACITY), .BW(BW)) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key    (s_tdata[63:0]),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  chm_ram #(.DEPTH(CAPACITY), .AW(BW), .DW(IW)) u_head (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(bh_raddr), .rdata(bh_rdata)
  );

  chm_ram #(.DEPTH(CAPACITY), .AW(BW), .DW(IW)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  chm_ram #(.DEPTH(CAPACITY), .AW(BW), .DW(KEY_W)) u_key (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(key),
    .raddr(nd_raddr), .rdata(key_rdata)
  );

  chm_ram #(.DEPTH(CAPACITY), .AW(BW), .DW(VAL_W)) u_val (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(val),
    .raddr(nd_raddr), .rdata(val_rdata)
  );

  chm_ram #(.DEPTH(CAPACITY), .AW(BW), .DW(IW)) u_link (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .raddr(nd_raddr), .rdata(ln_rdata)
  );

  // memory port steering
  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = bkt;
    bh_wdata = nlink;
    bh_raddr = bkt;
    st_we    = 1'b0;
    st_waddr = used_dec[BW-1:0];
    st_wdata = cur;
    st_raddr = used[BW-1:0];
    nd_we    = 1'b0;
    nd_waddr = st_rdata[BW-1:0];
    nd_raddr = cur[BW-1:0];
    ln_we    = 1'b0;
    ln_waddr = prev[BW-1:0];
    ln_wdata = nlink;
    case (state)
      S_SWEEP: begin
        // empty bucket and identity free stack at the same index
        bh_we    = 1'b1;
        bh_waddr = sw_idx[BW-1:0];
        bh_wdata = NULL_IDX;
        st_we    = 1'b1;
        st_waddr = sw_idx[BW-1:0];
        st_wdata = sw_idx;
      end
      S_HEADW: begin
        nd_raddr = bh_rdata[BW-1:0];
      end
      S_CMP: begin
        nd_raddr = ln_rdata[BW-1:0];
      end
      S_UNLINK: begin
        if (prev != NULL_IDX) begin
          ln_we = 1'b1;
        end else begin
          bh_we = 1'b1;
        end
        st_we = 1'b1;
      end
      S_POPW: begin
        // new node: key, value and a null link
        nd_we    = 1'b1;
        ln_we    = 1'b1;
        ln_waddr = st_rdata[BW-1:0];
        ln_wdata = NULL_IDX;
      end
      S_THEADW: begin
        if (bh_rdata == NULL_IDX) begin
          bh_we    = 1'b1;
          bh_wdata = newnode;
        end
        nd_raddr = bh_rdata[BW-1:0];
      end
      S_TWALK: begin
        if (ln_rdata == NULL_IDX) begin
          ln_we    = 1'b1;
          ln_waddr = cur[BW-1:0];
          ln_wdata = newnode;
        end
        nd_raddr = ln_rdata[BW-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sw_idx      <= '0;
      sw_from_req <= 1'b0;
      used        <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // a word taken while the next one is loaded keeps m_tvalid high
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sw_idx <= sw_idx + 1'b1;
          if (sw_idx == IW'(CAPACITY - 1)) begin
            used  <= '0;
            state <= sw_from_req ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req     <= req_t'(s_tuser);
            key     <= s_tdata[63:0];
            val     <= s_tdata[127:64];
            res_hit <= 1'b0;
            res_err <= 1'b0;
            res_val <= '0;
            if (req_t'(s_tuser) == REQ_CLEAR) begin
              sw_idx      <= '0;
              sw_from_req <= 1'b1;
              state       <= S_SWEEP;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bkt   <= hash_bkt;
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= S_HEADW;
        end
        S_HEADW: begin
          cur   <= bh_rdata;
          prev  <= NULL_IDX;
          steps <= '0;
          if (bh_rdata == NULL_IDX) begin
            // empty chain: key absent
            case (req)
              REQ_GET: begin
                res_val <= '1;
                state   <= S_OUT;
              end
              REQ_SET: state <= S_INS;
              default: state <= S_OUT;
            endcase
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (key_rdata == key) begin
            nlink <= ln_rdata;
            if (req == REQ_GET) begin
              res_hit <= 1'b1;
              res_val <= val_rdata;
              state   <= S_OUT;
            end else begin
              state <= S_UNLINK;
            end
          end else begin
            prev  <= cur;
            cur   <= ln_rdata;
            steps <= steps_inc;
            if (ln_rdata == NULL_IDX || steps_inc == NULL_IDX) begin
              case (req)
                REQ_GET: begin
                  res_val <= '1;
                  state   <= S_OUT;
                end
                REQ_SET: state <= S_INS;
                default: state <= S_OUT;
              endcase
            end
          end
        end
        S_UNLINK: begin
          used  <= used_dec;
          state <= (req == REQ_SET) ? S_INS : S_OUT;
        end
        S_INS: begin
          if (used == NULL_IDX) begin
            // pool full: drop the insert
            res_err <= 1'b1;
            state   <= S_OUT;
          end else begin
            state <= S_POPW;
          end
        end
        S_POPW: begin
          newnode <= st_rdata;
          used    <= used + 1'b1;
          state   <= S_THEAD;
        end
        S_THEAD: begin
          state <= S_THEADW;
        end
        S_THEADW: begin
          cur   <= bh_rdata;
          state <= (bh_rdata == NULL_IDX) ? S_OUT : S_TWALK;
        end
        S_TWALK: begin
          cur <= ln_rdata;
          if (ln_rdata == NULL_IDX) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_hit  <= res_hit;
            out_err  <= res_err;
            out_val  <= res_val;
            out_cnt  <= COUNT_W'(used);
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used <= NULL_IDX)
    else $error("live count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request taken while busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("result word not loaded by sequencer");

  a_err_no_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_err && out_hit))
    else $error("hit and full error together");

  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !s_tready)
    else $error("request taken during sweep");

endmodule
